// ----- rtl/blsamp_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and constants of the bicubic lagrange sampler
// no dependencies; imported by every other file except blsamp_ram
package blsamp_pkg;

    localparam int DEF_MAX_WIDTH       = 512;
    localparam int DEF_MAX_HEIGHT      = 512;
    localparam int DEF_MAX_CHANNELS    = 4;
    localparam int DEF_COORD_FRAC_BITS = 8;

    // request and result field widths
    localparam int OPC_W   = 1;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 9;
    localparam int CHAN_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 21;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int DIM_W      = 10;
    localparam int CCNT_W     = 3;

    localparam logic [OPC_W-1:0] OPC_WRITE  = 1'b0;
    localparam logic [OPC_W-1:0] OPC_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 10'd512;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 10'd512;
    localparam logic [CCNT_W-1:0] RST_CHANNEL_COUNT = 3'd1;

    // weight fraction bits and shared multiplier shape
    localparam int WFRAC   = 16;
    localparam int WGT_W   = 19;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 48;

    // reciprocal of three, exact for 16-bit operands
    localparam logic [16:0] DIV3_MUL = 17'd43691;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_WGT   = 6'b000100,
        S_PIX   = 6'b001000,
        S_FIN   = 6'b010000,
        S_RND   = 6'b100000
    } t_state;

    // what the product register holds in the cycle after a multiply
    typedef enum logic [3:0] {
        WB_NONE,
        WB_TMP,
        WB_W0,
        WB_W1,
        WB_W2,
        WB_W3,
        WB_ROW0,
        WB_ROW,
        WB_ACC
    } t_wb;

endpackage

// ----- rtl/blsamp_req_if.sv -----
`timescale 1ns / 1ps
// request channel: write or sample items with valid/ready
// depends on blsamp_pkg
interface blsamp_req_if;
    import blsamp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OPC_W-1:0]          opcode;
    logic [COL_W-1:0]          pixel_col;
    logic [ROW_W-1:0]          pixel_row;
    logic [CHAN_W-1:0]         channel;
    logic [BYTE_W-1:0]         pixel_byte;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;

    modport source (
        output valid, opcode, pixel_col, pixel_row, channel, pixel_byte, coord_x, coord_y,
        input  ready
    );
    modport sink (
        input  valid, opcode, pixel_col, pixel_row, channel, pixel_byte, coord_x, coord_y,
        output ready
    );
endinterface

// ----- rtl/blsamp_res_if.sv -----
`timescale 1ns / 1ps
// result channel: one interpolated sample value with valid/ready
// depends on blsamp_pkg
interface blsamp_res_if;
    import blsamp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] sample_value;

    modport source (output valid, sample_value, input ready);
    modport sink   (input valid, sample_value, output ready);
endinterface

// ----- rtl/blsamp_cfg_if.sv -----
`timescale 1ns / 1ps
// configuration write channel: register index and data with valid/ready
// depends on blsamp_pkg
interface blsamp_cfg_if;
    import blsamp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/bicubic_lagrange_sampler_core.sv -----
`timescale 1ns / 1ps
// bicubic lagrange sampler: image store plus a sequenced 4x4 lagrange interpolator
// write: S_WRITE, then idle; sample: weight phase, neighbour phase, S_FIN, S_RND
// (12 weight multiplies, then 4 rows of 4 memory reads + 1 row multiply each)
// one request at a time; weight and pixel products share the single multiplier
// reset: size registers to 512x512, one channel; image store is not cleared
module bicubic_lagrange_sampler_core #(
    parameter int MAX_WIDTH       = blsamp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = blsamp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS    = blsamp_pkg::DEF_MAX_CHANNELS,
    parameter int COORD_FRAC_BITS = blsamp_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    blsamp_req_if.sink    i_req,
    blsamp_res_if.source  o_res,
    blsamp_cfg_if.sink    i_cfg
);
    import blsamp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int FL_W  = COORD_W + 2;
    localparam logic [FL_W-2:0] MW = (FL_W-1)'(MAX_WIDTH);
    localparam logic [FL_W-2:0] MH = (FL_W-1)'(MAX_HEIGHT);
    localparam logic [MUL_P_W-1:0] RND_W03 = MUL_P_W'(64'd3 << 32);
    localparam logic [MUL_P_W-1:0] RND_W12 = MUL_P_W'(64'd1 << 32);
    localparam logic [ACC_W-1:0]   RND_OUT = ACC_W'(64'd1 << 31);

    t_state r_state;
    t_wb    r_wb, n_wb;
    logic   r_wb_axis;
    logic [2:0] r_cnt;
    logic       r_axis;
    logic [1:0] r_row;

    logic [COL_W-1:0]          r_col;
    logic [ROW_W-1:0]          r_prow;
    logic [CHAN_W-1:0]         r_ch;
    logic [BYTE_W-1:0]         r_byte;
    logic signed [COORD_W-1:0] r_cx, r_cy;

    logic [DIM_W-1:0]  r_img_w, r_img_h;
    logic [CCNT_W-1:0] r_chan_cnt;

    logic signed [WGT_W-1:0]   r_wx [4];
    logic signed [WGT_W-1:0]   r_wy [4];
    logic [MUL_A_W-1:0]        r_tmp;
    logic signed [MUL_A_W-1:0] r_rowv;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_pv;
    logic                      r_out_valid;
    logic [BYTE_W-1:0]         r_out_value;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic [BYTE_W-1:0] rd_data;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;

    logic req_acc, load_out;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // axis operands: u, S-u, 2S-u, S+u
    logic [WFRAC-1:0] u_x, u_y, u_s;
    logic [WFRAC:0]   op_b, op_d;
    logic [WFRAC+1:0] op_c;
    assign u_x  = WFRAC'(r_cx[COORD_FRAC_BITS-1:0]) << (WFRAC - COORD_FRAC_BITS);
    assign u_y  = WFRAC'(r_cy[COORD_FRAC_BITS-1:0]) << (WFRAC - COORD_FRAC_BITS);
    assign u_s  = r_axis ? u_y : u_x;
    assign op_b = (WFRAC+1)'(1 << WFRAC) - (WFRAC+1)'(u_s);
    assign op_c = (WFRAC+2)'(2 << WFRAC) - (WFRAC+2)'(u_s);
    assign op_d = (WFRAC+1)'(1 << WFRAC) + (WFRAC+1)'(u_s);

    // neighbour position and bounds
    logic signed [COORD_W-1:0] fx, fy;
    logic [FL_W-1:0] nb_col, nb_row;
    logic [FL_W-2:0] w_eff, h_eff;
    logic            ch_ok, pix_ok;
    assign fx     = r_cx >>> COORD_FRAC_BITS;
    assign fy     = r_cy >>> COORD_FRAC_BITS;
    assign nb_col = FL_W'(fx) + FL_W'(r_cnt[1:0]) - FL_W'(1);
    assign nb_row = FL_W'(fy) + FL_W'(r_row) - FL_W'(1);
    assign w_eff  = ((FL_W-1)'(r_img_w) < MW) ? (FL_W-1)'(r_img_w) : MW;
    assign h_eff  = ((FL_W-1)'(r_img_h) < MH) ? (FL_W-1)'(r_img_h) : MH;
    assign ch_ok  = (CCNT_W'(r_ch) < r_chan_cnt) && (32'(r_ch) < MAX_CHANNELS);
    assign pix_ok = (r_state == S_PIX) && !r_cnt[2] && ch_ok
                  && !nb_col[FL_W-1] && (nb_col[FL_W-2:0] < w_eff)
                  && !nb_row[FL_W-1] && (nb_row[FL_W-2:0] < h_eff);

    function automatic logic [AW-1:0] store_addr(
        input logic [FL_W-2:0]   row,
        input logic [FL_W-2:0]   col,
        input logic [CHAN_W-1:0] ch
    );
        return AW'((32'(row) * MAX_WIDTH + 32'(col)) * MAX_CHANNELS + 32'(ch));
    endfunction

    always_comb begin
        if (r_state == S_WRITE) begin
            ram_addr = store_addr((FL_W-1)'(r_prow), (FL_W-1)'(r_col), r_ch);
        end else begin
            ram_addr = store_addr(nb_row[FL_W-2:0], nb_col[FL_W-2:0], r_ch);
        end
    end
    assign ram_we = (r_state == S_WRITE) && (32'(r_col) < MAX_WIDTH)
                  && (32'(r_prow) < MAX_HEIGHT) && (32'(r_ch) < MAX_CHANNELS);

    blsamp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_byte),
        .o_rdata (rd_data)
    );

    // operand selection for the shared multiplier
    logic [1:0] px_idx;
    assign px_idx = 2'(r_cnt - 3'd1);
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        n_wb  = WB_NONE;
        unique case (r_state)
            S_WGT: begin
                case (r_cnt)
                    3'd0: begin
                        mul_a = MUL_A_W'(u_s);
                        mul_b = MUL_B_W'(op_b);
                        n_wb  = WB_TMP;
                    end
                    3'd1: begin
                        mul_a = prod[MUL_A_W-1:0];
                        mul_b = MUL_B_W'(op_c);
                        n_wb  = WB_W0;
                    end
                    3'd2: begin
                        mul_a = r_tmp;
                        mul_b = MUL_B_W'(op_d);
                        n_wb  = WB_W3;
                    end
                    3'd3: begin
                        mul_a = MUL_A_W'(op_d);
                        mul_b = MUL_B_W'(op_c);
                        n_wb  = WB_TMP;
                    end
                    3'd4: begin
                        mul_a = prod[MUL_A_W-1:0];
                        mul_b = MUL_B_W'(op_b);
                        n_wb  = WB_W1;
                    end
                    default: begin
                        mul_a = r_tmp;
                        mul_b = MUL_B_W'(u_s);
                        n_wb  = WB_W2;
                    end
                endcase
            end
            S_PIX: begin
                if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                    mul_a = MUL_A_W'(r_wx[px_idx]);
                    mul_b = r_pv ? MUL_B_W'(rd_data) : '0;
                    n_wb  = (r_cnt == 3'd1) ? WB_ROW0 : WB_ROW;
                end else if (r_cnt == 3'd6) begin
                    mul_a = r_rowv;
                    mul_b = r_wy[r_row];
                    n_wb  = WB_ACC;
                end
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    blsamp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // product conversion into weights: outer weights carry the division by three
    logic [MUL_P_W-1:0] sum03, sum12;
    logic [15:0]        q16;
    logic [32:0]        q3x;
    logic [15:0]        q3;
    logic [WFRAC:0]     w12;
    logic signed [WGT_W-1:0] w_neg, w_pos;
    assign sum03 = prod + RND_W03;
    assign sum12 = prod + RND_W12;
    assign q16   = sum03[48:33];
    assign q3x   = 33'(q16) * 33'(DIV3_MUL);
    assign q3    = q3x[32:17];
    assign w12   = sum12[49:33];
    assign w_neg = -$signed({3'b000, q3});
    assign w_pos = $signed({2'b00, w12});

    always_ff @(posedge i_clk) begin
        case (r_wb)
            WB_TMP:  r_tmp <= prod[MUL_A_W-1:0];
            WB_W0:   if (r_wb_axis) r_wy[0] <= w_neg; else r_wx[0] <= w_neg;
            WB_W1:   if (r_wb_axis) r_wy[1] <= w_pos; else r_wx[1] <= w_pos;
            WB_W2:   if (r_wb_axis) r_wy[2] <= w_pos; else r_wx[2] <= w_pos;
            WB_W3:   if (r_wb_axis) r_wy[3] <= w_neg; else r_wx[3] <= w_neg;
            WB_ROW0: r_rowv <= prod[MUL_A_W-1:0];
            WB_ROW:  r_rowv <= r_rowv + prod[MUL_A_W-1:0];
            default: r_tmp <= r_tmp;
        endcase
        if (r_state == S_WGT && r_cnt == 3'd5 && r_axis) begin
            r_acc <= '0;
        end else if (r_wb == WB_ACC) begin
            r_acc <= r_acc + prod[ACC_W-1:0];
        end
        if (req_acc) begin
            r_col  <= i_req.pixel_col;
            r_prow <= i_req.pixel_row;
            r_ch   <= i_req.channel;
            r_byte <= i_req.pixel_byte;
            r_cx   <= i_req.coord_x;
            r_cy   <= i_req.coord_y;
        end
        r_wb_axis <= r_axis;
    end

    // round half away from zero and clamp; negative sums clamp to zero
    logic [ACC_W-1:0] acc_rnd;
    logic [BYTE_W-1:0] out_val;
    assign acc_rnd = r_acc + RND_OUT;
    always_comb begin
        if (r_acc[ACC_W-1]) begin
            out_val = '0;
        end else if (acc_rnd[ACC_W-1:32] > (ACC_W-32)'(255)) begin
            out_val = 8'd255;
        end else begin
            out_val = acc_rnd[39:32];
        end
    end
    assign load_out = (r_state == S_RND) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_row       <= '0;
            r_wb        <= WB_NONE;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_img_w     <= RST_IMAGE_WIDTH;
            r_img_h     <= RST_IMAGE_HEIGHT;
            r_chan_cnt  <= RST_CHANNEL_COUNT;
        end else begin
            r_wb <= n_wb;
            r_pv <= pix_ok;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_IMAGE_WIDTH:   r_img_w    <= i_cfg.data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT:  r_img_h    <= i_cfg.data[DIM_W-1:0];
                    REG_CHANNEL_COUNT: r_chan_cnt <= i_cfg.data[CCNT_W-1:0];
                    default:           r_chan_cnt <= r_chan_cnt;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out_value <= out_val;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_cnt  <= '0;
                        r_axis <= 1'b0;
                        r_state <= (i_req.opcode == OPC_WRITE) ? S_WRITE : S_WGT;
                    end
                end
                S_WRITE: r_state <= S_IDLE;
                S_WGT: begin
                    if (r_cnt == 3'd5) begin
                        r_cnt <= '0;
                        if (r_axis) begin
                            r_row   <= '0;
                            r_state <= S_PIX;
                        end else begin
                            r_axis <= 1'b1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_PIX: begin
                    if (r_cnt == 3'd6) begin
                        r_cnt <= '0;
                        if (r_row == 2'd3) begin
                            r_state <= S_FIN;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_FIN: r_state <= S_RND;
                S_RND: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.sample_value = r_out_value;

    // a write request never produces a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.opcode == OPC_WRITE) |=> !$rose(r_out_valid))
        else $error("write request raised a result");

    // weight phase only hands over to the neighbour phase
    a_wgt_to_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WGT) |=> (r_state == S_WGT || r_state == S_PIX))
        else $error("weight phase left to an unexpected state");

    // a negative weighted sum saturates to zero
    a_neg_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_acc[ACC_W-1]) |=> (o_res.sample_value == '0))
        else $error("negative sum not clamped");

    // store is only written in the write state
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIX) |-> !ram_we && (r_wb != WB_W0 || !r_pv))
        else $error("store written while sampling");
endmodule

// ----- rtl/blsamp_ram.sv -----
`timescale 1ns / 1ps
// generic single-port ram with registered read data
// no dependencies
module blsamp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/blsamp_mul.sv -----
`timescale 1ns / 1ps
// shared signed multiplier with registered product
// depends on blsamp_pkg for operand widths
module blsamp_mul (
    input  logic                                 i_clk,
    input  logic signed [blsamp_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [blsamp_pkg::MUL_B_W-1:0] i_b,
    output logic signed [blsamp_pkg::MUL_P_W-1:0] o_p
);
    import blsamp_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;
endmodule

// ----- bench/bicubic_lagrange_sampler_core_test.sv -----
`timescale 1ns / 1ps
// self-checking test of bicubic_lagrange_sampler_core: pixel writes, bicubic samples, size setup
// depends on blsamp_pkg and the request, result and configuration interfaces
module bicubic_lagrange_sampler_core_test;
    import blsamp_pkg::*;

    typedef struct packed {
        logic [OPC_W-1:0]          opcode;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic [CHAN_W-1:0]         chan;
        logic [BYTE_W-1:0]         pix;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } req_t;

    localparam longint STORE_W = DEF_MAX_WIDTH;
    localparam longint STORE_H = DEF_MAX_HEIGHT;
    localparam longint STORE_C = DEF_MAX_CHANNELS;

    // register index past the end of the list, ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    class sample_scoreboard;
        logic [BYTE_W-1:0] image_mem[int];
        logic [BYTE_W-1:0] pending_samples[$];
        int unsigned img_w = 32'(RST_IMAGE_WIDTH);
        int unsigned img_h = 32'(RST_IMAGE_HEIGHT);
        int unsigned chans = 32'(RST_CHANNEL_COUNT);
        int errors = 0;

        function automatic longint round_div(longint n, longint d);
            return (n >= 0) ? (n + d / 2) / d : -((-n + d / 2) / d);
        endfunction

        // floor of a coordinate and its four Q.16 lagrange weights
        function automatic longint split_axis(longint c, output longint wt[4]);
            longint s, den, f, u;
            s = 64'sd1 << WFRAC;
            den = 64'sd6 << (2 * WFRAC);
            f = c & ((64'sd1 << DEF_COORD_FRAC_BITS) - 1);
            u = f << (WFRAC - DEF_COORD_FRAC_BITS);
            wt[0] = round_div(-u * (u - s) * (u - 2 * s), den);
            wt[1] = round_div(3 * (s + u) * (u - s) * (u - 2 * s), den);
            wt[2] = round_div(-3 * (s + u) * u * (u - 2 * s), den);
            wt[3] = round_div((s + u) * u * (u - s), den);
            return (c - f) / (64'sd1 << DEF_COORD_FRAC_BITS);
        endfunction

        function automatic int mem_key(longint r, longint c, int unsigned ch);
            return int'((r * STORE_W + c) * STORE_C + longint'(ch));
        endfunction

        function automatic bit in_image(longint r, longint c);
            longint ew, eh;
            ew = (longint'(img_w) < STORE_W) ? longint'(img_w) : STORE_W;
            eh = (longint'(img_h) < STORE_H) ? longint'(img_h) : STORE_H;
            return r >= 0 && c >= 0 && r < eh && c < ew;
        endfunction

        // neighbours of a sample that the block would read but nobody has written yet
        function automatic void unwritten_taps(req_t r, ref int keys[$]);
            longint wx[4], wy[4], fx, fy;
            keys.delete();
            if (32'(r.chan) >= chans) return;
            fx = split_axis(longint'(r.cx), wx);
            fy = split_axis(longint'(r.cy), wy);
            for (int j = 0; j < 4; j++)
                for (int i = 0; i < 4; i++)
                    if (in_image(fy - 1 + j, fx - 1 + i) &&
                        !image_mem.exists(mem_key(fy - 1 + j, fx - 1 + i, 32'(r.chan))))
                        keys.push_back(mem_key(fy - 1 + j, fx - 1 + i, 32'(r.chan)));
        endfunction

        function automatic void note_request(req_t r);
            longint wx[4], wy[4], fx, fy, acc, rowv, p, v;
            if (r.opcode == OPC_WRITE) begin
                image_mem[mem_key(longint'(r.row), longint'(r.col), 32'(r.chan))] = r.pix;
                return;
            end
            fx = split_axis(longint'(r.cx), wx);
            fy = split_axis(longint'(r.cy), wy);
            acc = 0;
            for (int j = 0; j < 4; j++) begin
                rowv = 0;
                for (int i = 0; i < 4; i++) begin
                    p = 0;
                    if (32'(r.chan) < chans && in_image(fy - 1 + j, fx - 1 + i))
                        p = longint'(image_mem[mem_key(fy - 1 + j, fx - 1 + i, 32'(r.chan))]);
                    rowv += wx[i] * p;
                end
                acc += wy[j] * rowv;
            end
            v = round_div(acc, 64'sd1 << (2 * WFRAC));
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            pending_samples.push_back(v[BYTE_W-1:0]);
        endfunction

        function automatic void check_result(logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] exp_v;
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample, got %0d", $time, got);
                errors++;
                return;
            end
            exp_v = pending_samples.pop_front();
            if (got !== exp_v) begin
                $display("%0t: sample_value mismatch, expected %0d got %0d", $time, exp_v, got);
                errors++;
            end
        endfunction

        function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_IMAGE_WIDTH:   img_w = 32'(d);
                REG_IMAGE_HEIGHT:  img_h = 32'(d);
                REG_CHANNEL_COUNT: chans = 32'(d[CCNT_W-1:0]);
                default: ;
            endcase
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int unsigned n_sent;
    sample_scoreboard sb;

    blsamp_req_if req ();
    blsamp_res_if res ();
    blsamp_cfg_if cfg ();

    bicubic_lagrange_sampler_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** bicubic_lagrange_sampler_core: FAILED **");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // result side back-pressure
    initial begin
        int stall;
        stall = 0;
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) sb.check_result(res.sample_value);
    end

    task automatic send_req(req_t r);
        int g;
        g = pick_gap();
        if (g > 0) begin
            req.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req.opcode     <= r.opcode;
        req.pixel_col  <= r.col;
        req.pixel_row  <= r.row;
        req.channel    <= r.chan;
        req.pixel_byte <= r.pix;
        req.coord_x    <= r.cx;
        req.coord_y    <= r.cy;
        req.valid      <= 1'b1;
        do @(posedge i_clk); while (!req.ready);
        sb.note_request(r);
        n_sent++;
    endtask

    task automatic write_pixel(int col, int row, int ch, int pix);
        req_t r;
        r = '0;
        r.opcode = OPC_WRITE;
        r.col = COL_W'(col);
        r.row = ROW_W'(row);
        r.chan = CHAN_W'(ch);
        r.pix = BYTE_W'(pix);
        send_req(r);
    endtask

    // writes any unwritten neighbour first so the block never reads an empty entry
    task automatic sample_at(int x, int y, int ch);
        req_t r;
        int keys[$];
        r = '0;
        r.opcode = OPC_SAMPLE;
        r.cx = COORD_W'(x);
        r.cy = COORD_W'(y);
        r.chan = CHAN_W'(ch);
        sb.unwritten_taps(r, keys);
        foreach (keys[k])
            write_pixel((keys[k] / 4) % 512, keys[k] / 2048, keys[k] % 4, $urandom_range(0, 255));
        send_req(r);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        // a trailing write request may still be in flight
        repeat (50) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int d);
        drain();
        cfg.index <= idx;
        cfg.data  <= CFG_DATA_W'(d);
        cfg.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.set_reg(idx, CFG_DATA_W'(d));
    endtask

    initial begin
        int pw[11] = '{512, 1, 4, 1023, 0, 7, 16, 512, 13, 600, 5};
        int ph[11] = '{512, 1, 4, 1023, 5, 0, 12, 1, 9, 3, 700};
        int pc[11] = '{1, 1, 4, 7, 2, 0, 3, 4, 2, 1, 4};
        int ew, eh, sel;
        int unsigned first_item;
        sb = new();
        n_sent = 0;
        req.valid = 1'b0;
        req.opcode = OPC_WRITE;
        req.pixel_col = '0;
        req.pixel_row = '0;
        req.channel = '0;
        req.pixel_byte = '0;
        req.coord_x = '0;
        req.coord_y = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_IMAGE_WIDTH;
        cfg.data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: store corners, integer and extreme coordinates, unused channel
        write_pixel(511, 511, 3, 255);
        write_pixel(0, 0, 0, 0);
        write_pixel(511, 0, 0, 255);
        sample_at(0, 0, 0);
        sample_at(2 * 256, 3 * 256, 0);
        sample_at(5 * 256 + 255, 7 * 256 + 255, 0);
        sample_at(510 * 256 + 128, 1, 0);
        sample_at(511 * 256, 511 * 256, 0);
        sample_at(-1048576, -1048576, 0);
        sample_at(1048575, 1048575, 0);
        sample_at(-256, -128, 0);
        sample_at(300, 300, 3);
        sample_at(40 * 256 + 128, 41 * 256 + 64, 1);
        for (int k = 0; k < 10; k++) write_pixel(100 + k % 4, 200 + k / 4, 0, (k & 1) ? 255 : 0);
        sample_at(101 * 256 + 128, 201 * 256 + 128, 0);
        drain();
        cfg_write(REG_UNUSED, 1023);

        for (int p = 0; p < $size(pw); p++) begin
            cfg_write(REG_IMAGE_WIDTH, pw[p]);
            cfg_write(REG_IMAGE_HEIGHT, ph[p]);
            cfg_write(REG_CHANNEL_COUNT, pc[p]);
            no_idle = (p % 4 == 3);
            ew = (pw[p] == 0) ? 4 : (pw[p] > 512 ? 512 : pw[p]);
            eh = (ph[p] == 0) ? 4 : (ph[p] > 512 ? 512 : ph[p]);
            if (ew > 24) ew = 24;
            if (eh > 24) eh = 24;
            first_item = n_sent;
            // neighbour fills count toward the request budget of each setup
            for (int n = 0; n < 100 && n_sent - first_item < 90; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    sample_at($urandom_range(0, (ew + 4) * 256) - 768,
                              $urandom_range(0, (eh + 4) * 256) - 768, $urandom_range(0, 3));
                else if (sel < 85)
                    write_pixel($urandom_range(0, 511), $urandom_range(0, 511),
                                $urandom_range(0, 3), $urandom_range(0, 255));
                else
                    sample_at($urandom, $urandom, $urandom_range(0, 3));
                // one hold-off until all samples are back
                if (p == 2 && n == 10) drain();
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending_samples.size() == 0)
            $display("** bicubic_lagrange_sampler_core: PASSED **");
        else
            $display("** bicubic_lagrange_sampler_core: FAILED **");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/blsamp_pkg.sv
rtl/blsamp_req_if.sv
rtl/blsamp_res_if.sv
rtl/blsamp_cfg_if.sv
rtl/blsamp_ram.sv
rtl/blsamp_mul.sv
rtl/bicubic_lagrange_sampler_core.sv
bench/bicubic_lagrange_sampler_core_test.sv
